@@ sv/titt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// titt_pkg: shared types and constants of the timer table
// slot record layout, operation codes, event codes
// ----------------------------------------------------------------------------
package titt_pkg;

	localparam int SLOTS   = 16;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int TIME_W  = 48;
	localparam int ID_W    = 31;
	localparam int MAX_OUT = 16;
	localparam int OUT_W   = $clog2(MAX_OUT + 1);
	localparam int OIDX_W  = $clog2(MAX_OUT);
	localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

	localparam logic [1:0] MODE_ONESHOT  = 2'd0;
	localparam logic [1:0] MODE_PERIODIC = 2'd1;
	localparam logic [1:0] MODE_CLEAR    = 2'd2;
	localparam logic [1:0] MODE_TICK     = 2'd3;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_CREATED = 3'd1;
	localparam logic [2:0] EV_FIRED   = 3'd2;
	localparam logic [2:0] EV_CLEARED = 3'd3;
	localparam logic [2:0] EV_FULL    = 3'd4;

	// one slot record as held in the slot memory
	typedef struct packed {
		logic              periodic;
		logic [ID_W-1:0]   period;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] expiry;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

endpackage
`default_nettype wire

@@ sv/timeout_interval_timer_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// timeout_interval_timer_table: one-shot and periodic millisecond timer table
// ----------------------------------------------------------------------------
// usage
// - s_axis carries one command word: create one-shot, create periodic,
//   clear by id, or a one millisecond tick; the mode travels in tuser
// - m_axis returns one or more result words per command, tlast on the final
//   one; every word of a command carries the same active and next-delay status
// - slot records live in one memory of 16 entries with a registered read;
//   valid bits are flip-flops, cleared at reset, so no clearing pass is needed
// - each pass over the memory reads one slot a cycle
// - create and clear take two passes, a search and a status pass
// - a tick takes one pass per fired timer plus a search and a status pass,
//   at most 16 fired a tick; when all 16 fire, the last search, which would
//   find nothing, is skipped
// - then one word a cycle while m_axis_tready is high
// - one command at a time: s_axis_tready is low from acceptance until the
//   last result word has been taken
// - a stalled receiver just holds the current result word on m_axis
// - reset clears time, valid bits and the id counter (next id is 1)
// ----------------------------------------------------------------------------
module timeout_interval_timer_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // operand[31:0]
	input  wire logic [1:0]  s_axis_tuser,   // mode[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // timer_id[30:0], active[31],
	                                         // next_delay[62:32], pad
	output logic [2:0]       m_axis_tuser,   // event_res[2:0]
	output logic             m_axis_tlast
);
	import titt_pkg::*;

	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [SLOT_W-1:0] ram_raddr;
	slot_rec_t         ram_wdata;
	slot_rec_t         ram_rdata;
	logic [REC_W-1:0]  ram_rbits;
	logic [ID_W-1:0]   o_id;
	logic              o_active;
	logic [ID_W-1:0]   o_delay;

	assign ram_rdata = slot_rec_t'(ram_rbits);

	// slot record memory
	titt_ram #(
		.WIDTH(REC_W),
		.DEPTH(SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(REC_W'(ram_wdata)),
		.raddr(ram_raddr),
		.rdata(ram_rbits)
	);

	// command sequencer
	titt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser),
		.in_operand(s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_id    (o_id),
		.out_ev    (m_axis_tuser),
		.out_last  (m_axis_tlast),
		.out_active(o_active),
		.out_delay (o_delay),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	assign m_axis_tdata = {1'b0, o_delay, o_active, o_id};
endmodule
`default_nettype wire

@@ sv/titt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// titt_ram: generic single-port-write, single-read RAM
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module titt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ sv/titt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// titt_ctrl: sequencer of the timer table
// scans the slot memory one entry a cycle per pass, updates slots, emits words
// ----------------------------------------------------------------------------
module titt_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                in_mode,
	input  wire logic [31:0]               in_operand,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [titt_pkg::ID_W-1:0]      out_id,
	output logic [2:0]                     out_ev,
	output logic                           out_last,
	output logic                           out_active,
	output logic [titt_pkg::ID_W-1:0]      out_delay,
	output logic                           ram_we,
	output logic [titt_pkg::SLOT_W-1:0]    ram_waddr,
	output titt_pkg::slot_rec_t            ram_wdata,
	output logic [titt_pkg::SLOT_W-1:0]    ram_raddr,
	input  titt_pkg::slot_rec_t            ram_rdata
);
	import titt_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_ACT  = 6'b000100,
		ST_STAT = 6'b001000,
		ST_EMIT = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t              state_q;
	logic [1:0]          mode_q;
	logic [31:0]         op_q;
	logic [TIME_W-1:0]   now_q;
	logic [ID_W-1:0]     next_id_q;
	logic [SLOTS-1:0]    valid_q;
	logic [CNT_W-1:0]    cnt_q;       // scan counter, also read-data tag
	logic                rd_s1;       // read data valid this cycle
	logic [SLOT_W-1:0]   rdidx_s1;
	// scan results
	logic                hit_q;
	logic [SLOT_W-1:0]   hit_idx_q;
	logic                free_q;
	logic [SLOT_W-1:0]   free_idx_q;
	logic                due_q;
	logic [SLOT_W-1:0]   due_idx_q;
	slot_rec_t           due_rec_q;
	logic                any_q;
	logic [TIME_W-1:0]   min_q;
	// output fifo of event words (id, code)
	logic [ID_W-1:0]     fid_q [MAX_OUT];
	logic [2:0]          fev_q [MAX_OUT];
	logic [OUT_W-1:0]    fcnt_q;
	logic [OUT_W-1:0]    rptr_q;
	logic                stat_pass_q; // current scan is the status pass
	logic [ID_W-1:0]     delay_q;
	logic                active_q;

	logic [SLOT_W-1:0]   ridx;
	logic [31:0]         dly;
	logic                due_here;
	logic                better;
	logic [TIME_W-1:0]   diff;
	logic                clr_hit;
	logic                more_due;

	assign ridx = cnt_q[SLOT_W-1:0];
	assign ram_raddr = ridx;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		if (op_q[31]) begin
			dly = (mode_q == MODE_PERIODIC) ? 32'd1 : 32'd0;
		end else if (mode_q == MODE_PERIODIC && op_q == 32'd0) begin
			dly = 32'd1;
		end else begin
			dly = op_q;
		end
	end

	// a clear only matches a positive id
	assign clr_hit = hit_q && !op_q[31] && op_q != 32'd0;
	// another tick search pass while timers were due and the word buffer has room
	assign more_due = (mode_q == MODE_TICK) && due_q &&
		(fcnt_q + OUT_W'(1) < OUT_W'(MAX_OUT));

	assign due_here = valid_q[rdidx_s1] && (ram_rdata.expiry <= now_q);
	assign better = !due_q || (ram_rdata.expiry < due_rec_q.expiry) ||
		(ram_rdata.expiry == due_rec_q.expiry && ram_rdata.id < due_rec_q.id);
	assign diff = min_q - now_q;

	// slot write on the action step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = due_idx_q;
		ram_wdata = due_rec_q;
		if (state_q == ST_ACT) begin
			case (mode_q)
				MODE_ONESHOT, MODE_PERIODIC: begin
					ram_we    = hit_q || free_q;
					ram_waddr = hit_q ? hit_idx_q : free_idx_q;
					ram_wdata.expiry   = now_q + TIME_W'(dly);
					ram_wdata.id       = next_id_q;
					ram_wdata.periodic = (mode_q == MODE_PERIODIC);
					ram_wdata.period   = (mode_q == MODE_PERIODIC) ? dly[ID_W-1:0] : '0;
				end
				MODE_TICK: begin
					ram_we    = due_q && due_rec_q.periodic;
					ram_wdata.expiry = now_q + TIME_W'(due_rec_q.period);
				end
				default: ram_we = 1'b0;
			endcase
		end
	end

	assign out_valid  = (state_q == ST_OUT);
	assign out_id     = fid_q[rptr_q[OIDX_W-1:0]];
	assign out_ev     = fev_q[rptr_q[OIDX_W-1:0]];
	assign out_last   = (rptr_q + OUT_W'(1) == fcnt_q);
	assign out_active = active_q;
	assign out_delay  = delay_q;

	always_ff @(posedge clk) begin
		rdidx_s1 <= ridx;
		if (state_q == ST_ACT) begin
			case (mode_q)
				MODE_ONESHOT, MODE_PERIODIC: begin
					fid_q[0] <= (hit_q || free_q) ? next_id_q : '0;
					fev_q[0] <= (hit_q || free_q) ? EV_CREATED : EV_FULL;
				end
				MODE_CLEAR: begin
					fid_q[0] <= clr_hit ? op_q[ID_W-1:0] : '0;
					fev_q[0] <= clr_hit ? EV_CLEARED : EV_NONE;
				end
				default: begin
					if (due_q) begin
						fid_q[fcnt_q[OIDX_W-1:0]] <= due_rec_q.id;
						fev_q[fcnt_q[OIDX_W-1:0]] <= EV_FIRED;
					end else if (fcnt_q == '0) begin
						fid_q[0] <= '0;
						fev_q[0] <= EV_NONE;
					end
				end
			endcase
		end
		if (state_q == ST_SCAN && rd_s1) begin
			if (ram_rdata.id == (mode_q == MODE_CLEAR ? op_q[ID_W-1:0] : next_id_q)
				&& valid_q[rdidx_s1] && !hit_q) begin
				hit_idx_q <= rdidx_s1;
			end
			if (!valid_q[rdidx_s1] && !free_q) begin
				free_idx_q <= rdidx_s1;
			end
			if (due_here && better) begin
				due_idx_q <= rdidx_s1;
				due_rec_q <= ram_rdata;
			end
			if (valid_q[rdidx_s1] && (!any_q || ram_rdata.expiry < min_q)) begin
				min_q <= ram_rdata.expiry;
			end
		end
		if (state_q == ST_EMIT) begin
			active_q <= any_q;
			if (any_q && min_q > now_q) begin
				delay_q <= (diff > TIME_W'(ID_MAX)) ? ID_MAX : diff[ID_W-1:0];
			end else begin
				delay_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= '0;
			next_id_q   <= ID_W'(1);
			valid_q     <= '0;
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			due_q       <= 1'b0;
			any_q       <= 1'b0;
			fcnt_q      <= '0;
			rptr_q      <= '0;
			stat_pass_q <= 1'b0;
			mode_q      <= MODE_TICK;
			op_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q      <= in_mode;
						op_q        <= in_operand;
						cnt_q       <= '0;
						rd_s1       <= 1'b0;
						hit_q       <= 1'b0;
						free_q      <= 1'b0;
						due_q       <= 1'b0;
						any_q       <= 1'b0;
						fcnt_q      <= '0;
						rptr_q      <= '0;
						stat_pass_q <= 1'b0;
						if (in_mode == MODE_TICK) begin
							now_q <= now_q + TIME_W'(1);
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// one read issued per cycle, its data compared in the following cycle
					rd_s1 <= (cnt_q < CNT_W'(SLOTS));
					if (cnt_q < CNT_W'(SLOTS)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (rd_s1) begin
						if (valid_q[rdidx_s1]) begin
							any_q <= 1'b1;
							if (mode_q == MODE_CLEAR ? ram_rdata.id == op_q[ID_W-1:0]
								: ram_rdata.id == next_id_q) begin
								hit_q <= 1'b1;
							end
						end else begin
							free_q <= 1'b1;
						end
						if (due_here) begin
							due_q <= 1'b1;
						end
					end
					if (!rd_s1 && cnt_q == CNT_W'(SLOTS)) begin
						state_q <= stat_pass_q ? ST_EMIT : ST_ACT;
					end
				end
				ST_ACT: begin
					cnt_q  <= '0;
					rd_s1  <= 1'b0;
					any_q  <= 1'b0;
					hit_q  <= 1'b0;
					free_q <= 1'b0;
					due_q  <= 1'b0;
					stat_pass_q <= !more_due;
					state_q <= ST_SCAN;
					case (mode_q)
						MODE_ONESHOT, MODE_PERIODIC: begin
							fcnt_q <= OUT_W'(1);
							if (hit_q || free_q) begin
								valid_q[hit_q ? hit_idx_q : free_idx_q] <= 1'b1;
								next_id_q <= (next_id_q == ID_MAX || next_id_q == '0)
									? ID_W'(1) : next_id_q + ID_W'(1);
							end
						end
						MODE_CLEAR: begin
							fcnt_q <= OUT_W'(1);
							if (clr_hit) begin
								valid_q[hit_idx_q] <= 1'b0;
							end
						end
						default: begin
							if (due_q) begin
								fcnt_q <= fcnt_q + OUT_W'(1);
								if (!due_rec_q.periodic) begin
									valid_q[due_idx_q] <= 1'b0;
								end
							end else if (fcnt_q == '0) begin
								fcnt_q <= OUT_W'(1);
							end
						end
					endcase
				end
				ST_EMIT: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						if (out_last) begin
							state_q <= ST_IDLE;
						end else begin
							rptr_q <= rptr_q + OUT_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
